### hw/rtl/mos_pkg.sv
// Shared types and constants of the multiobjective scalarizer.
package mos_pkg;

    localparam int unsigned DATA_W = 48;

    localparam logic signed [DATA_W-1:0] MAX48 = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN48 = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_TCHEB = 2'd0,
        MODE_WSUM  = 2'd1,
        MODE_AUG   = 2'd2
    } t_mode;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic        [DATA_W-1:0] term;
        logic signed [DATA_W-1:0] wy;
    } t_prod;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] max;
        logic signed [DATA_W-1:0] sum;
    } t_final;

endpackage

### hw/rtl/mos_front.sv
// Input register and product stage of the multiobjective scalarizer.
module mos_front
    import mos_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_objective_value,
    input  logic signed [31:0] i_ideal_value,
    input  logic        [16:0] i_weight,
    input  logic               i_last_objective,
    input  logic               i_s2_take,
    output t_prod              o_prod
);

    localparam int unsigned   EPS_Q_INT = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam logic [16:0]   EPS_Q     = 17'(EPS_Q_INT);

    logic               r_s1_valid;
    logic signed [31:0] r_y;
    logic signed [31:0] r_ideal;
    logic        [16:0] r_w;
    logic               r_last;

    logic               r_s2_valid;
    logic               r_s2_last;
    logic [DATA_W-1:0]  r_term;
    logic signed [DATA_W-1:0] r_wy;

    logic               s2_free;
    logic               s1_take;
    logic               in_take;
    logic signed [32:0] diff;
    logic        [32:0] mag;
    logic        [16:0] w_eff;
    logic        [49:0] prod;
    logic signed [49:0] wy_full;
    logic [DATA_W-1:0]  n_term;
    logic signed [DATA_W-1:0] n_wy;

    assign s2_free    = !r_s2_valid || i_s2_take;
    assign s1_take    = r_s1_valid && s2_free;
    assign o_in_stall = r_s1_valid && !s2_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign diff    = 33'(r_y) - 33'(r_ideal);
    assign mag     = diff[32] ? 33'(-diff) : 33'(diff);
    assign w_eff   = (r_w == '0) ? EPS_Q : r_w;
    assign prod    = 50'(mag) * 50'(w_eff);
    assign wy_full = 50'($signed({1'b0, r_w})) * 50'(r_y);
    assign n_term  = DATA_W'(prod >> FRAC_BITS);
    assign n_wy    = DATA_W'(wy_full >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_take) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_take) begin
                r_s2_valid <= 1'b1;
            end else if (i_s2_take) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_y     <= i_objective_value;
            r_ideal <= i_ideal_value;
            r_w     <= i_weight;
            r_last  <= i_last_objective;
        end
        if (s1_take) begin
            r_s2_last <= r_last;
            r_term    <= n_term;
            r_wy      <= n_wy;
        end
    end

    assign o_prod.valid = r_s2_valid;
    assign o_prod.last  = r_s2_last;
    assign o_prod.term  = r_term;
    assign o_prod.wy    = r_wy;

endmodule

### hw/rtl/mos_accum.sv
// Running maximum and running sum accumulators with end-of-vector capture.
module mos_accum
    import mos_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_prod  i_prod,
    input  logic   i_out_free,
    output logic   o_s2_take,
    output t_final o_final
);

    logic signed [DATA_W-1:0] r_max;
    logic signed [DATA_W-1:0] r_sum;
    logic                     r_fin_valid;
    logic signed [DATA_W-1:0] r_fin_max;
    logic signed [DATA_W-1:0] r_fin_sum;

    logic                     s3_free;
    logic                     take;
    logic signed [DATA_W-1:0] n_max;
    logic signed [DATA_W:0]   sum_wide;
    logic signed [DATA_W-1:0] n_sum;

    assign s3_free   = !r_fin_valid || i_out_free;
    assign take      = i_prod.valid && (!i_prod.last || s3_free);
    assign o_s2_take = take;

    assign n_max    = ($signed(i_prod.term) > r_max) ? $signed(i_prod.term) : r_max;
    assign sum_wide = {r_sum[DATA_W-1], r_sum} + {i_prod.wy[DATA_W-1], i_prod.wy};

    always_comb begin
        if (sum_wide[DATA_W] != sum_wide[DATA_W-1]) begin
            n_sum = sum_wide[DATA_W] ? MIN48 : MAX48;
        end else begin
            n_sum = sum_wide[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= MIN48;
            r_sum       <= '0;
            r_fin_valid <= 1'b0;
        end else begin
            if (take) begin
                if (i_prod.last) begin
                    r_max <= MIN48;
                    r_sum <= '0;
                end else begin
                    r_max <= n_max;
                    r_sum <= n_sum;
                end
            end
            if (take && i_prod.last) begin
                r_fin_valid <= 1'b1;
            end else if (i_out_free) begin
                r_fin_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_prod.last) begin
            r_fin_max <= n_max;
            r_fin_sum <= n_sum;
        end
    end

    assign o_final.valid = r_fin_valid;
    assign o_final.max   = r_fin_max;
    assign o_final.sum   = r_fin_sum;

endmodule

### hw/rtl/mos_out.sv
// Fitness selection and output register of the multiobjective scalarizer.
module mos_out
    import mos_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_final            i_final,
    input  t_mode             i_mode,
    input  logic              i_out_stall,
    output logic              o_out_free,
    output logic              o_out_valid,
    output logic signed [47:0] o_fitness
);

    localparam int unsigned EPS_Q_INT = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam int unsigned PW        = DATA_W + 18;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_fitness;

    logic                     load;
    logic signed [PW-1:0]     eps_prod;
    logic signed [PW-1:0]     aug_wide;
    logic signed [DATA_W-1:0] aug;
    logic signed [DATA_W-1:0] n_fitness;

    assign o_out_free = !r_out_valid || !i_out_stall;
    assign load       = i_final.valid && o_out_free;

    assign eps_prod = PW'($signed({1'b0, 17'(EPS_Q_INT)})) * PW'(i_final.sum);
    assign aug_wide = PW'(i_final.max) + (eps_prod >>> FRAC_BITS);

    always_comb begin
        if (aug_wide > PW'(MAX48)) begin
            aug = MAX48;
        end else if (aug_wide < PW'(MIN48)) begin
            aug = MIN48;
        end else begin
            aug = aug_wide[DATA_W-1:0];
        end
    end

    always_comb begin
        case (i_mode)
            MODE_WSUM: begin
                n_fitness = i_final.sum;
            end
            MODE_AUG: begin
                n_fitness = aug;
            end
            default: begin
                n_fitness = i_final.max;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_fitness <= n_fitness;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_fitness   = r_fitness;

endmodule

### hw/rtl/multiobjective_scalarizer_core.sv
// Multiobjective scalarizer top: Tchebycheff, weighted-sum and augmented fitness.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one objective per word:
//   objective value and ideal value (signed Q16.16), weight (unsigned Q1.16)
//   and a last flag marking the final objective of the vector.
//   Output channel (o_out_valid / i_out_stall) carries one fitness word
//   (signed Q32.16, saturated) for each vector, after its last objective.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the 2-bit
//   scalarization mode: 0 Tchebycheff, 1 weighted sum, 2 augmented; 3 acts
//   as 0. Write it only while no vector is in flight.
//   Throughput: one objective per cycle while o_in_stall is low, set by the
//   register update of the running maximum and running sum.
//   After the last objective is accepted, its fitness word passes through
//   the input, product, capture and output registers in that order.
//   Reset (synchronous, active low) empties the pipeline, clears the running
//   sum, sets the running maximum to its most negative value and the mode
//   to Tchebycheff.
//   A stalled output holds its word; the pipeline keeps filling its empty
//   stages, and o_in_stall rises once no stage can take another word.
module multiobjective_scalarizer_core
    import mos_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [1:0]  i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_objective_value,
    input  logic signed [31:0] i_ideal_value,
    input  logic        [16:0] i_weight,
    input  logic               i_last_objective,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [47:0] o_fitness
);

    t_mode  r_mode;
    t_prod  prod;
    t_final fin;
    logic   s2_take;
    logic   out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TCHEB;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    mos_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_objective_value(i_objective_value),
        .i_ideal_value    (i_ideal_value),
        .i_weight         (i_weight),
        .i_last_objective (i_last_objective),
        .i_s2_take        (s2_take),
        .o_prod           (prod)
    );

    mos_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_prod    (prod),
        .i_out_free(out_free),
        .o_s2_take (s2_take),
        .o_final   (fin)
    );

    mos_out #(
        .FRAC_BITS(FRAC_BITS)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_final    (fin),
        .i_mode     (r_mode),
        .i_out_stall(i_out_stall),
        .o_out_free (out_free),
        .o_out_valid(o_out_valid),
        .o_fitness  (o_fitness)
    );

endmodule
